// ----- src/lbe_pkg.sv -----
package lbe_pkg;

   localparam int DIR_W    = 16;
   localparam int AXIS_W   = 32;
   localparam int DOT_W    = 48;
   localparam int MSB_W    = 6;
   localparam int MANT_W   = 31;
   localparam int FRAC_W   = 16;
   localparam int E_W      = 40;
   localparam int VALUE_W  = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int NUM_LOBE_REGS = 2;
   localparam int NUM_CHAN_REGS = 3;

   // per lobe: 2 product/sum, 18 log, 1 exponent multiply, 18 power
   localparam int LOG_LAT  = 2 + FRAC_W;
   localparam int EXP_LAT  = 2 + FRAC_W;
   localparam int LOBE_LAT = 2 + LOG_LAT + 1 + EXP_LAT;

   localparam logic [CSR_IDX_W-1:0] REG_LOBE_COUNT  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIFFUSE_RGB = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOBE0_RED   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOBE0_GREEN = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOBE0_BLUE  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LOBE1_RED   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOBE1_GREEN = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LOBE1_BLUE  = 4'd7;

   localparam logic [VALUE_W-1:0] SAT32   = 32'hFFFF_FFFF;
   localparam logic [MANT_W-1:0]  ONE30   = 31'h4000_0000;
   localparam logic signed [E_W-1:0] E_HI_LIM = 40'sh00_1000_0000;
   localparam logic signed [E_W-1:0] E_LO_LIM = -40'sh00_2000_0000;
   localparam logic signed [E_W-1:0] E_BIAS   = 40'sh00_2000_0000;
   localparam logic [MSB_W-1:0] INT_TOP  = 6'd47;
   localparam logic [MSB_W-1:0] SHIFT_REF = 6'd46;
   localparam logic [MSB_W-1:0] NORM_POS = 6'd30;

   typedef logic signed [DIR_W-1:0]  dir_type;
   typedef logic signed [AXIS_W-1:0] axis_type;
   typedef logic [VALUE_W-1:0]       value_type;

   typedef struct packed {
      logic [15:0]        n;
      logic signed [15:0] cz;
      logic signed [15:0] cy;
      logic signed [15:0] cx;
   } lobe_coef_type;

   typedef struct packed {
      logic              pos;
      logic [MSB_W-1:0]  p;
      logic [FRAC_W-1:0] frac;
   } log_type;

   typedef logic [MANT_W-1:0] fac_table_type [FRAC_W];

   // 2^(2^-(k+1)) in Q1.30, each a floor square root of the one before
   function automatic fac_table_type build_fac();
      fac_table_type t;
      logic [63:0]   v;
      logic [63:0]   r;
      logic [63:0]   c;
      v = 64'd2 << 60;
      for (int k = 0; k < FRAC_W; k++) begin
         r = '0;
         for (int i = 31; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if (c * c <= v) r = c;
         end
         t[k] = r[MANT_W-1:0];
         v = r << 30;
      end
      return t;
   endfunction

   localparam fac_table_type FAC = build_fac();

endpackage

// ----- src/lbe_if.sv -----
interface lbe_req_if import lbe_pkg::*; ();
   logic    valid;
   logic    ready;
   dir_type light_x;
   dir_type light_y;
   dir_type light_z;
   dir_type view_x;
   dir_type view_y;
   dir_type view_z;
   modport source (output valid, light_x, light_y, light_z, view_x, view_y, view_z,
                   input ready);
   modport sink (input valid, light_x, light_y, light_z, view_x, view_y, view_z,
                 output ready);
endinterface

interface lbe_rsp_if import lbe_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type red_value;
   value_type green_value;
   value_type blue_value;
   modport source (output valid, red_value, green_value, blue_value, input ready);
   modport sink (input valid, red_value, green_value, blue_value, output ready);
endinterface

// ----- src/lbe_log2.sv -----
module lbe_log2 import lbe_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic signed [DOT_W-1:0] dot_in,
   output log_type                 log_out
);

   logic [DOT_W-2:0]  mag_ff;
   logic [MSB_W-1:0]  enc_p_ff;
   logic              enc_pos_ff;
   logic [MSB_W-1:0]  p_in;
   logic [MANT_W-1:0] norm_in;
   logic [DOT_W-2:0]  shifted;

   logic [MANT_W-1:0] m_ff    [FRAC_W+1];
   logic [FRAC_W-1:0] frac_ff [FRAC_W+1];
   logic [MSB_W-1:0]  p_ff    [FRAC_W+1];
   logic              pos_ff  [FRAC_W+1];

   logic [2*MANT_W-1:0] sq      [FRAC_W];
   logic [MANT_W-1:0]   m_in    [FRAC_W];
   logic                bit_in  [FRAC_W];

   // leading one
   always_comb begin
      p_in = '0;
      for (int i = 1; i < DOT_W - 1; i++) begin
         if (dot_in[i]) p_in = MSB_W'(i);
      end
   end

   always_comb begin
      if (enc_p_ff >= NORM_POS) begin
         shifted = mag_ff >> (enc_p_ff - NORM_POS);
      end else begin
         shifted = mag_ff << (NORM_POS - enc_p_ff);
      end
      norm_in = shifted[MANT_W-1:0];
   end

   always_comb begin
      for (int k = 0; k < FRAC_W; k++) begin
         sq[k] = (2*MANT_W)'(m_ff[k]) * (2*MANT_W)'(m_ff[k]);
         bit_in[k] = sq[k][2*MANT_W-1];
         m_in[k] = bit_in[k] ? sq[k][2*MANT_W-1:MANT_W] : sq[k][2*MANT_W-2:MANT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff     <= dot_in[DOT_W-2:0];
         enc_p_ff   <= p_in;
         enc_pos_ff <= (dot_in > 0);
         m_ff[0]    <= norm_in;
         frac_ff[0] <= '0;
         p_ff[0]    <= enc_p_ff;
         pos_ff[0]  <= enc_pos_ff;
         for (int k = 0; k < FRAC_W; k++) begin
            m_ff[k+1]    <= m_in[k];
            frac_ff[k+1] <= {frac_ff[k][FRAC_W-2:0], bit_in[k]};
            p_ff[k+1]    <= p_ff[k];
            pos_ff[k+1]  <= pos_ff[k];
         end
      end
   end

   assign log_out = '{pos: pos_ff[FRAC_W], p: p_ff[FRAC_W], frac: frac_ff[FRAC_W]};

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (en && enc_pos_ff) |=> m_ff[0][MANT_W-1] == 1'b1)
      else $error("mantissa not normalized");

endmodule

// ----- src/lbe_exp2.sv -----
module lbe_exp2 import lbe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic signed [E_W-1:0] e_in,
   input  logic                  pos_in,
   output value_type             value_out
);

   logic signed [E_W-1:0] ue;
   logic [MANT_W-1:0] r_ff   [FRAC_W+1];
   logic [FRAC_W-1:0] f_ff   [FRAC_W+1];
   logic [MSB_W-1:0]  hi_ff  [FRAC_W+1];
   logic              sat_ff [FRAC_W+1];
   logic              zero_ff[FRAC_W+1];
   logic [2*MANT_W-1:0] prod [FRAC_W];
   logic [MANT_W-1:0]   r_in [FRAC_W];
   value_type value_ff;
   value_type shift_in;

   assign ue = e_in + E_BIAS;

   always_comb begin
      for (int k = 0; k < FRAC_W; k++) begin
         prod[k] = (2*MANT_W)'(r_ff[k]) * (2*MANT_W)'(FAC[k]);
         r_in[k] = f_ff[k][FRAC_W-1-k] ? prod[k][2*MANT_W-2:MANT_W-1] : r_ff[k];
      end
   end

   always_comb begin
      if (hi_ff[FRAC_W] == INT_TOP) begin
         shift_in = {r_ff[FRAC_W], 1'b0};
      end else begin
         shift_in = VALUE_W'({1'b0, r_ff[FRAC_W]} >> (SHIFT_REF - hi_ff[FRAC_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= ONE30;
         f_ff[0]    <= ue[23:8];
         hi_ff[0]   <= ue[29:24];
         sat_ff[0]  <= pos_in && (e_in >= E_HI_LIM);
         zero_ff[0] <= !pos_in || (e_in < E_LO_LIM);
         for (int k = 0; k < FRAC_W; k++) begin
            r_ff[k+1]    <= r_in[k];
            f_ff[k+1]    <= f_ff[k];
            hi_ff[k+1]   <= hi_ff[k];
            sat_ff[k+1]  <= sat_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
         if (zero_ff[FRAC_W]) begin
            value_ff <= '0;
         end else if (sat_ff[FRAC_W]) begin
            value_ff <= SAT32;
         end else begin
            value_ff <= shift_in;
         end
      end
   end

   assign value_out = value_ff;

   a_sat_out: assert property (@(posedge clock) disable iff (reset)
      (en && sat_ff[FRAC_W]) |=> value_ff == SAT32)
      else $error("saturated lobe not at full scale");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      sat_ff[0] |-> !zero_ff[0])
      else $error("lobe both saturated and zero");

endmodule

// ----- src/lbe_lobe.sv -----
module lbe_lobe import lbe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  axis_type      dx,
   input  axis_type      dy,
   input  axis_type      dz,
   input  lobe_coef_type coef,
   output value_type     contrib
);

   logic signed [DOT_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [DOT_W-1:0] px_in, py_in, pz_in;
   logic signed [DOT_W-1:0] dot_ff;
   log_type                 log_q;
   logic signed [6:0]       pm40;
   logic signed [22:0]      l_val;
   logic signed [E_W-1:0]   e_in;
   logic signed [E_W-1:0]   e_ff;
   logic                    pos_ff;

   assign px_in = coef.cx * dx;
   assign py_in = coef.cy * dy;
   assign pz_in = coef.cz * dz;

   always_comb begin
      pm40  = $signed({1'b0, log_q.p}) - 7'sd40;
      l_val = {pm40, log_q.frac};
      e_in  = $signed({1'b0, coef.n}) * l_val;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         pz_ff  <= pz_in;
         dot_ff <= px_ff + py_ff + pz_ff;
         e_ff   <= e_in;
         pos_ff <= log_q.pos;
      end
   end

   lbe_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .dot_in  (dot_ff),
      .log_out (log_q)
   );

   lbe_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .e_in      (e_ff),
      .pos_in    (pos_ff),
      .value_out (contrib)
   );

endmodule

// ----- src/lafortune_brdf_eval_core.sv -----
// Lafortune reflectance evaluator: one beat of light/view direction in, one beat of
// red/green/blue Q16.16 reflectance out, one beat per cycle sustained; the whole
// pipeline holds while a result waits unread. The per-axis products are registered,
// then each lobe unit does the coefficient products and dot sum, leading-one search
// and normalize, sixteen squaring stages for the log, the exponent multiply, sixteen
// factor multiplies and the final shift; the diffuse add is registered at the output.
// Registers must be written only with the pipeline empty; the block does not check.
module lafortune_brdf_eval_core import lbe_pkg::*; #(
   parameter int MAX_LOBES = 2,
   parameter int CHANNELS  = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   lbe_req_if.sink               req_bus,
   lbe_rsp_if.source             rsp_bus,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PIPE_LAT = LOBE_LAT + 2;

   logic [1:0]       lobe_cnt_ff;
   logic [47:0]      diffuse_ff;
   lobe_coef_type    coef_ff [NUM_LOBE_REGS][NUM_CHAN_REGS];
   logic [PIPE_LAT-1:0] valid_ff;
   logic             en;
   axis_type         dx_ff, dy_ff, dz_ff;
   axis_type         dx_in, dy_in, dz_in;
   value_type        contrib [MAX_LOBES][CHANNELS];
   value_type        out_in  [3];
   value_type        out_ff  [3];
   logic [1:0]       lobes;
   logic [VALUE_W:0] sum;
   logic [VALUE_W:0] step;

   assign en = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = en;

   assign dx_in = req_bus.light_x * req_bus.view_x;
   assign dy_in = req_bus.light_y * req_bus.view_y;
   assign dz_in = req_bus.light_z * req_bus.view_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         lobe_cnt_ff <= '0;
         diffuse_ff  <= '0;
         for (int l = 0; l < NUM_LOBE_REGS; l++) begin
            for (int c = 0; c < NUM_CHAN_REGS; c++) begin
               coef_ff[l][c] <= '0;
            end
         end
      end else if (csr_write_en) begin
         case (csr_index)
            REG_LOBE_COUNT:  lobe_cnt_ff   <= csr_data[1:0];
            REG_DIFFUSE_RGB: diffuse_ff    <= csr_data[47:0];
            REG_LOBE0_RED:   coef_ff[0][0] <= csr_data;
            REG_LOBE0_GREEN: coef_ff[0][1] <= csr_data;
            REG_LOBE0_BLUE:  coef_ff[0][2] <= csr_data;
            REG_LOBE1_RED:   coef_ff[1][0] <= csr_data;
            REG_LOBE1_GREEN: coef_ff[1][1] <= csr_data;
            REG_LOBE1_BLUE:  coef_ff[1][2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PIPE_LAT-2:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         for (int c = 0; c < 3; c++) out_ff[c] <= out_in[c];
      end
   end

   for (genvar l = 0; l < MAX_LOBES; l++) begin : g_lobe
      for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
         lbe_lobe u_lobe (
            .clock   (clock),
            .reset   (reset),
            .en      (en),
            .dx      (dx_ff),
            .dy      (dy_ff),
            .dz      (dz_ff),
            .coef    (coef_ff[l][c]),
            .contrib (contrib[l][c])
         );
      end
   end

   assign lobes = (lobe_cnt_ff > 2'(MAX_LOBES)) ? 2'(MAX_LOBES) : lobe_cnt_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) out_in[c] = '0;
      sum  = '0;
      step = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         sum = (VALUE_W+1)'({diffuse_ff[16*c +: 16], 8'h00});
         for (int l = 0; l < MAX_LOBES; l++) begin
            if (2'(l) < lobes) begin
               step = sum + {1'b0, contrib[l][c]};
               sum  = step[VALUE_W] ? {1'b0, SAT32} : step;
            end
         end
         out_in[c] = sum[VALUE_W-1:0];
      end
   end

   assign rsp_bus.valid       = valid_ff[PIPE_LAT-1];
   assign rsp_bus.red_value   = out_ff[0];
   assign rsp_bus.green_value = out_ff[1];
   assign rsp_bus.blue_value  = out_ff[2];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved during stall");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import lbe_pkg::*;

   localparam int CYCLE_LIMIT  = 800000;
   localparam int RAND_PHASES  = 8;
   localparam int BEATS_PHASE  = 140;

   typedef struct {
      dir_type lx, ly, lz, vx, vy, vz;
   } dirs_type;

   typedef struct {
      value_type red, green, blue;
   } rgb_type;

   typedef struct {
      int       group;
      dirs_type dirs;
      bit       typed;
      rgb_type  rgb;
   } row_type;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   lbe_req_if req_bus ();
   lbe_rsp_if rsp_bus ();

   lafortune_brdf_eval_core uut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // shadow of the register file
   logic [1:0]    lobes_cfg;
   logic [47:0]   diffuse_cfg;
   lobe_coef_type coef_cfg [2][3];
   logic [63:0]   pow_fac [1:16];

   rgb_type pending_rgb [$];
   int      errors;
   int      checked;
   longint  cycles;
   bit      no_idle;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // (d / 2^40) ^ (n / 2^8) as Q16.16, d > 0
   function automatic logic [63:0] lobe_pow(input logic [63:0] d, input logic [15:0] n);
      int          p;
      int          e;
      logic [63:0] m;
      logic [63:0] frac;
      logic [63:0] ue;
      logic [63:0] f16;
      logic [63:0] r;
      longint      lg;
      longint      ex;
      p = 0;
      for (int i = 63; i >= 0; i--) begin
         if (d[i]) begin
            p = i;
            break;
         end
      end
      m = (p >= 30) ? (d >> (p - 30)) : (d << (30 - p));
      frac = 0;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac |= 1;
            m >>= 1;
         end
      end
      lg = longint'(p - 40) * 65536 + longint'(frac);
      ex = longint'({48'd0, n}) * lg;
      if (ex >= (longint'(16) << 24)) return 64'hFFFF_FFFF;
      if (ex < -(longint'(32) << 24)) return 0;
      ue = ex + (longint'(32) << 24);
      e = int'(ue >> 24) - 32;
      f16 = (ue & 64'hFF_FFFF) >> 8;
      r = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
         if (f16[16 - k]) r = (r * pow_fac[k]) >> 30;
      if (e <= 14) r >>= (14 - e);
      else r <<= 1;
      return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
   endfunction

   function automatic rgb_type shade(input dirs_type s);
      longint      dx, dy, dz, dot;
      int          lobes;
      logic [63:0] acc [3];
      rgb_type     o;
      dx = longint'(s.lx) * longint'(s.vx);
      dy = longint'(s.ly) * longint'(s.vy);
      dz = longint'(s.lz) * longint'(s.vz);
      lobes = (lobes_cfg > 2) ? 2 : lobes_cfg;
      for (int c = 0; c < 3; c++) begin
         acc[c] = {48'd0, diffuse_cfg[16*c +: 16]} << 8;
         for (int l = 0; l < lobes; l++) begin
            dot = longint'(coef_cfg[l][c].cx) * dx + longint'(coef_cfg[l][c].cy) * dy
                + longint'(coef_cfg[l][c].cz) * dz;
            if (dot > 0) acc[c] += lobe_pow(dot, coef_cfg[l][c].n);
            if (acc[c] > 64'hFFFF_FFFF) acc[c] = 64'hFFFF_FFFF;
         end
      end
      o.red = acc[0][31:0];
      o.green = acc[1][31:0];
      o.blue = acc[2][31:0];
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic dir_type rand_dir();
      case ($urandom_range(0, 9))
         0: return dir_type'($urandom);
         1: begin
            case ($urandom_range(0, 4))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sd16384;
               3: return -16'sd16384;
               default: return 16'sd0;
            endcase
         end
         default: return dir_type'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic lobe_coef_type rand_coef();
      lobe_coef_type w;
      w.cx = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h3000) - 16'h1800);
      w.cy = ($urandom_range(0, 3) == 0) ? w.cx : 16'($urandom_range(0, 16'h3000) - 16'h1800);
      w.cz = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h3000) - 16'h1800);
      case ($urandom_range(0, 7))
         0: w.n = 16'h0000;
         1: w.n = 16'($urandom);
         2: w.n = 16'hFFFF;
         default: w.n = 16'($urandom_range(1, 16'h0800));
      endcase
      return w;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == REG_LOBE_COUNT) lobes_cfg = val[1:0];
      else if (idx == REG_DIFFUSE_RGB) diffuse_cfg = val[47:0];
      else if (idx <= REG_LOBE1_BLUE)
         coef_cfg[(idx - REG_LOBE0_RED) / 3][(idx - REG_LOBE0_RED) % 3] = val;
   endtask

   task automatic drain();
      while (pending_rgb.size() != 0) @(negedge clock);
      repeat (LOBE_LAT + 8) @(negedge clock);
   endtask

   task automatic send_beat(input dirs_type s, input bit typed, input rgb_type t);
      int g;
      req_bus.valid = 1'b1;
      req_bus.light_x = s.lx;
      req_bus.light_y = s.ly;
      req_bus.light_z = s.lz;
      req_bus.view_x = s.vx;
      req_bus.view_y = s.vy;
      req_bus.view_z = s.vz;
      do @(posedge clock); while (!req_bus.ready);
      pending_rgb.push_back(typed ? t : shade(s));
      @(negedge clock);
      g = pick_gap();
      if (g > 0) begin
         req_bus.valid = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   // result side: random backpressure, compare against oldest expectation
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else begin
            rsp_bus.ready = 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rgb_type x;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rgb.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            x = pending_rgb.pop_front();
            checked++;
            if (rsp_bus.red_value !== x.red) begin
               $error("red_value expected %h got %h", x.red, rsp_bus.red_value);
               errors++;
            end
            if (rsp_bus.green_value !== x.green) begin
               $error("green_value expected %h got %h", x.green, rsp_bus.green_value);
               errors++;
            end
            if (rsp_bus.blue_value !== x.blue) begin
               $error("blue_value expected %h got %h", x.blue, rsp_bus.blue_value);
               errors++;
            end
         end
      end
   end

   row_type rows [] = '{
      '{0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1, '{0, 0, 0}},
      '{0, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0}, 1, '{0, 0, 0}},
      '{0, '{16'sd16384, -16'sd16384, 16'sd0, 16'sd16384, -16'sd16384, 16'sd0}, 1, '{0, 0, 0}},
      // unit lobe, zero exponent: positive dot gives one, negative gives zero
      '{1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1,
            '{32'h10000, 32'h10000, 32'h10000}},
      '{1, '{16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0}, 1, '{0, 0, 0}},
      '{1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, '{0, 0, 0}},
      '{1, '{16'sd5, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0}, 1,
            '{32'h10000, 32'h10000, 32'h10000}},
      '{2, '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}, 0, '{0, 0, 0}},
      '{2, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0, '{0, 0, 0}},
      '{2, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 0, '{0, 0, 0}},
      '{2, '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 0, '{0, 0, 0}},
      '{2, '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1}, 0, '{0, 0, 0}},
      '{2, '{16'sd8192, 16'sd8192, 16'sd0, 16'sd8192, 16'sd4096, 16'sd0}, 0, '{0, 0, 0}},
      '{2, '{16'sd0, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 0, '{0, 0, 0}},
      '{2, '{-16'sd9000, 16'sd3000, 16'sd12000, -16'sd9000, -16'sd3000, 16'sd12000}, 0, '{0, 0, 0}},
      '{2, '{16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0}, 0, '{0, 0, 0}}
   };

   task automatic apply_group(input int grp);
      lobe_coef_type w;
      if (grp == 1) begin
         w = '{n: 16'h0000, cz: 16'sh1000, cy: 16'sh1000, cx: 16'sh1000};
         csr_write(REG_LOBE_COUNT, 64'd1);
         csr_write(REG_LOBE0_RED, w);
         csr_write(REG_LOBE0_GREEN, w);
         csr_write(REG_LOBE0_BLUE, w);
      end else if (grp == 2) begin
         // count above the maximum, full diffuse, huge and tiny powers
         csr_write(REG_LOBE_COUNT, 64'd3);
         csr_write(REG_DIFFUSE_RGB, 64'hFFFF_FFFF_FFFF_FFFF);
         csr_write(REG_LOBE0_RED,
                   lobe_coef_type'{n: 16'h1000, cz: 16'sh7FFF, cy: 16'sh7FFF, cx: 16'sh7FFF});
         csr_write(REG_LOBE0_GREEN,
                   lobe_coef_type'{n: 16'hFFFF, cz: 16'sh0800, cy: 16'sh0800, cx: 16'sh0800});
         csr_write(REG_LOBE0_BLUE,
                   lobe_coef_type'{n: 16'h0100, cz: 16'sh8000, cy: 16'sh8000, cx: 16'sh8000});
         csr_write(REG_LOBE1_RED,
                   lobe_coef_type'{n: 16'h0080, cz: 16'sh1000, cy: 16'sh1000, cx: 16'sh1000});
         csr_write(REG_LOBE1_GREEN,
                   lobe_coef_type'{n: 16'h0001, cz: 16'sh0001, cy: 16'sh0001, cx: 16'sh0001});
         csr_write(REG_LOBE1_BLUE,
                   lobe_coef_type'{n: 16'h2000, cz: -16'sh1000, cy: 16'sh2000, cx: 16'sh2000});
         csr_write(REG_LOBE1_BLUE + 4'd1, 64'hDEAD_BEEF_0123_4567);
         csr_write(4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
      end
   endtask

   initial begin
      dirs_type s;
      rgb_type  none;
      int       grp;
      logic [63:0] dv;
      errors = 0;
      checked = 0;
      cycles = 0;
      no_idle = 1'b0;
      none = '{0, 0, 0};
      lobes_cfg = 0;
      diffuse_cfg = 0;
      for (int a = 0; a < 2; a++)
         for (int b = 0; b < 3; b++) coef_cfg[a][b] = '0;
      pow_fac[1] = floor_sqrt(64'd2 << 60);
      for (int k = 2; k <= 16; k++) pow_fac[k] = floor_sqrt(pow_fac[k - 1] << 30);
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_bus.valid = 1'b0;
      {req_bus.light_x, req_bus.light_y, req_bus.light_z} = '0;
      {req_bus.view_x, req_bus.view_y, req_bus.view_z} = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      grp = 0;
      foreach (rows[i]) begin
         if (rows[i].group != grp) begin
            req_bus.valid = 1'b0;
            drain();
            grp = rows[i].group;
            apply_group(grp);
         end
         send_beat(rows[i].dirs, rows[i].typed, rows[i].rgb);
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         req_bus.valid = 1'b0;
         drain();
         no_idle = (ph % 3 == 2);
         case (ph)
            0: dv = 64'hFFFF_FFFF_FFFF;
            1: dv = 64'h0;
            default: dv = {$urandom, $urandom} & 64'h0000_0FFF_0FFF_0FFF;
         endcase
         csr_write(REG_LOBE_COUNT, 64'(ph % 4));
         csr_write(REG_DIFFUSE_RGB, dv);
         for (int r = REG_LOBE0_RED; r <= REG_LOBE1_BLUE; r++)
            csr_write(CSR_IDX_W'(r), rand_coef());
         for (int i = 0; i < BEATS_PHASE; i++) begin
            s = '{rand_dir(), rand_dir(), rand_dir(), rand_dir(), rand_dir(), rand_dir()};
            send_beat(s, 1'b0, none);
         end
      end
      req_bus.valid = 1'b0;
      no_idle = 1'b0;
      drain();

      $display("Checked %0d reflectance beats over %0d register settings (lobes 0..3).",
               checked, RAND_PHASES + 3);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
